// File: hw/rtl/cnv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cnv_pkg;

    localparam int SMP_W  = 16;
    localparam int FRAC_W = 12;
    localparam int SUM_W  = 48;
    localparam int FEAT_W = 31;
    localparam int CFG_W  = 4;

    localparam logic [1:0] ACT_TAP    = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic CFG_NUM_FILTERS = 1'b0;
    localparam logic CFG_KERNEL_TAPS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_TAIL,
        S_SUM,
        S_LOAD,
        S_DIV,
        S_OUT,
        S_CLR
    } t_state;

    // control broadcast to every filter cell
    typedef struct packed {
        logic conv_init;
        logic mul_en;
        logic acc_en;
        logic sum_en;
        logic shift;
        logic clr;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: hw/rtl/cnv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module cnv_cell #(
    parameter int MAX_TAPS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cnv_pkg::t_cell_ctl                i_ctl,
    input  wire logic                              i_en,
    input  wire logic                              i_tap_we,
    input  wire logic                              i_bias_we,
    input  wire logic [$clog2(MAX_TAPS+1)-1:0]     i_tap_wr_idx,
    input  wire logic signed [15:0]                i_coeff,
    input  wire logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_tap_idx,
    input  wire logic signed [15:0]                i_smp,
    input  wire logic [47:0]                       i_sum_in,
    output logic [47:0]                            o_sum
);
    import cnv_pkg::*;

    localparam int TIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW  = 32 + $clog2(MAX_TAPS + 1);

    logic signed [SMP_W-1:0]   r_taps [MAX_TAPS];
    logic signed [SMP_W-1:0]   r_bias;
    logic signed [2*SMP_W-1:0] r_prod;
    logic signed [CW-1:0]      r_conv;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          n_sum;
    logic [SUM_W:0]            w_add;
    logic                      w_pos;

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_taps[TIW'(i_tap_wr_idx)] <= i_coeff;
        end
        if (i_bias_we) begin
            r_bias <= i_coeff;
        end
        if (i_ctl.mul_en) begin
            r_prod <= i_smp * r_taps[i_tap_idx];
        end
        if (i_ctl.conv_init) begin
            r_conv <= {{(CW-SMP_W-FRAC_W){r_bias[SMP_W-1]}}, r_bias, {FRAC_W{1'b0}}};
        end else if (i_ctl.acc_en) begin
            r_conv <= r_conv + CW'(r_prod);
        end
    end

    // ReLU, drop fraction, saturating add
    assign w_pos = !r_conv[CW-1] && (|r_conv);
    assign w_add = {1'b0, r_sum} + (SUM_W+1)'(r_conv[CW-1:FRAC_W]);

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clr) begin
            n_sum = '0;
        end else if (i_ctl.shift) begin
            n_sum = i_sum_in;
        end else if (i_ctl.sum_en && i_en && w_pos) begin
            n_sum = w_add[SUM_W] ? {SUM_W{1'b1}} : w_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

// File: hw/rtl/cnv_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cnv_div #(
    parameter int DW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [47:0]   i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [47:0]        o_quot
);
    import cnv_pkg::*;

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [47:0]   r_q;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DW]) begin
                r_rem <= w_diff[DW-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DW-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// File: hw/rtl/conv1d_relu_avgpool_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake                 Payload
// s stream  in   i_s_tvalid / o_s_tready   tuser action; tdata filter_sel, tap_sel, coeff,
//                                          sample; tlast last
// m stream  out  o_m_tvalid / i_m_tready   tuser filter_id, overrun; tdata feature; tlast
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A load beat is taken in S_IDLE. A sample beat that completes a window runs S_MAC, S_TAIL and
// S_SUM: each filter cell runs its single multiplier over the taps, then adds the ReLU result.
// On the last sample, each filter in use passes S_LOAD, the shared bit-serial divider (S_DIV)
// and S_OUT, which waits for i_m_tready; then S_CLR clears the sequence state.
// Reset is synchronous, active low, and clears sums, count, overrun and the window.
// Input is held off (o_s_tready low) whenever a beat is in progress or a result waits.
module conv1d_relu_avgpool_encoder_top #(
    parameter int MAX_FILTERS = 8,
    parameter int MAX_TAPS    = 8,
    parameter int MAX_LEN     = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // filter_sel[2:0] tap_sel[5:3] coeff[21:6] sample[37:22]
    input  wire logic [1:0]  i_s_tuser,   // action[1:0]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // feature[30:0]
    output logic [3:0]       o_m_tuser,   // filter_id[2:0] overrun[3]
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);
    import cnv_pkg::*;

    localparam int TIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FIW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam int FCW = $clog2(MAX_FILTERS + 1);
    localparam int CNW = $clog2(MAX_LEN + 1);

    t_state r_state, n_state;
    t_cell_ctl w_ctl;

    logic [CFG_W-1:0]     r_nf, r_kt;
    logic [FCW-1:0]       w_nf;
    logic [TCW-1:0]       w_taps;
    logic signed [15:0]   r_win [MAX_TAPS];
    logic [CNW-1:0]       r_cnt, w_cnt_inc;
    logic                 r_ovr;
    logic                 r_last;
    logic [TIW-1:0]       r_base, r_k, w_min, w_widx;
    logic [CNW-1:0]       r_steps;
    logic [FIW-1:0]       r_f;
    logic                 r_mulv;
    logic [47:0]          w_sum [MAX_FILTERS+1];
    logic                 w_acc_now;
    logic                 w_drop;
    logic                 w_in_acc;
    logic                 w_is_smp;
    logic                 w_k_end;
    logic                 w_f_end;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [47:0]          w_quot;
    logic [2:0]           r_fid;
    logic [FEAT_W-1:0]    r_feat;
    logic                 r_ovr_o;
    logic                 r_lst;

    logic [2:0]           w_fsel, w_tsel;
    logic signed [15:0]   w_coeff, w_smp;

    assign w_fsel  = i_s_tdata[2:0];
    assign w_tsel  = i_s_tdata[5:3];
    assign w_coeff = i_s_tdata[21:6];
    assign w_smp   = i_s_tdata[37:22];

    // clamp register values into range
    assign w_nf   = (r_nf == '0) ? FCW'(1) :
                    (32'(r_nf) > MAX_FILTERS) ? FCW'(MAX_FILTERS) : FCW'(r_nf);
    assign w_taps = (r_kt == '0) ? TCW'(1) :
                    (32'(r_kt) > MAX_TAPS) ? TCW'(MAX_TAPS) : TCW'(r_kt);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf <= CFG_W'(8);
            r_kt <= CFG_W'(3);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_FILTERS: r_nf <= i_cfg_data;
                CFG_KERNEL_TAPS: r_kt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_is_smp  = w_in_acc && (i_s_tuser == ACT_SAMPLE);
    assign w_drop    = (32'(r_cnt) >= MAX_LEN);
    assign w_cnt_inc = r_cnt + CNW'(1);
    // accumulate on a full window, or once at the end of a short sequence
    assign w_acc_now = !w_drop && ((32'(w_cnt_inc) >= 32'(w_taps)) || i_s_tlast);

    // hold window, count, overrun, base and steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == S_CLR) begin
            r_cnt <= '0;
            r_ovr <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_is_smp) begin
            if (w_drop) begin
                r_ovr <= 1'b1;
            end else begin
                r_cnt    <= w_cnt_inc;
                r_win[0] <= w_smp;
                for (int i = 1; i < MAX_TAPS; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_smp) begin
            r_last <= i_s_tlast;
            if (32'(w_cnt_inc) >= 32'(w_taps)) begin
                r_base <= TIW'(32'(w_taps) - 1);
            end else begin
                r_base <= TIW'(32'(w_cnt_inc) - 1);
            end
            if (w_drop) begin
                r_steps <= (32'(r_cnt) >= 32'(w_taps)) ?
                           CNW'(32'(r_cnt) - 32'(w_taps) + 1) : CNW'(1);
            end else begin
                r_steps <= (32'(w_cnt_inc) >= 32'(w_taps)) ?
                           CNW'(32'(w_cnt_inc) - 32'(w_taps) + 1) : CNW'(1);
            end
        end
    end

    // tap k reads window entry base - min(k, base); short runs repeat the last sample
    assign w_min   = (r_k < r_base) ? r_k : r_base;
    assign w_widx  = r_base - w_min;
    assign w_k_end = (32'(r_k) + 1 == 32'(w_taps));
    assign w_f_end = (32'(r_f) + 1 == 32'(w_nf));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_f     <= '0;
            r_mulv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mulv  <= w_ctl.mul_en;
            if (r_state == S_MAC) begin
                r_k <= w_k_end ? '0 : r_k + TIW'(1);
            end
            if (r_state == S_OUT && i_m_tready) begin
                r_f <= w_f_end ? '0 : r_f + FIW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_is_smp) begin
                    if (w_acc_now) begin
                        n_state = S_MAC;
                    end else if (i_s_tlast) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_MAC:  n_state = w_k_end ? S_TAIL : S_MAC;
            S_TAIL: n_state = S_SUM;
            S_SUM:  n_state = r_last ? S_LOAD : S_IDLE;
            S_LOAD: n_state = S_DIV;
            S_DIV:  n_state = w_div_done ? S_OUT : S_DIV;
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = w_f_end ? S_CLR : S_LOAD;
                end
            end
            S_CLR:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl       = '0;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_MAC: begin
                w_ctl.conv_init = (r_k == '0);
                w_ctl.mul_en    = 1'b1;
                w_ctl.acc_en    = r_mulv;
            end
            S_TAIL: w_ctl.acc_en = r_mulv;
            S_SUM:  w_ctl.sum_en = 1'b1;
            S_LOAD: begin
                w_div_start  = 1'b1;
                w_ctl.shift  = 1'b1;
            end
            S_OUT:  o_m_tvalid = 1'b1;
            S_CLR:  w_ctl.clr = 1'b1;
            default: ;
        endcase
    end

    // filter cells; sums advance toward cell 0 on each unload
    assign w_sum[MAX_FILTERS] = '0;

    for (genvar g = 0; g < MAX_FILTERS; g++) begin : g_cell
        cnv_cell #(.MAX_TAPS(MAX_TAPS)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_en         (32'(w_nf) > g),
            .i_tap_we     (w_in_acc && i_s_tuser == ACT_TAP && 32'(w_fsel) == g &&
                           32'(w_tsel) < MAX_TAPS),
            .i_bias_we    (w_in_acc && i_s_tuser == ACT_BIAS && 32'(w_fsel) == g),
            .i_tap_wr_idx (TCW'(w_tsel)),
            .i_coeff      (w_coeff),
            .i_tap_idx    (r_k),
            .i_smp        (r_win[w_widx]),
            .i_sum_in     (w_sum[g+1]),
            .o_sum        (w_sum[g])
        );
    end

    cnv_div #(.DW(CNW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum[0]),
        .i_divisor  (r_steps),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_feat  <= (|w_quot[47:FEAT_W]) ? {FEAT_W{1'b1}} : w_quot[FEAT_W-1:0];
            r_fid   <= 3'(r_f);
            r_ovr_o <= r_ovr;
            r_lst   <= w_f_end;
        end
    end

    assign o_m_tdata = {1'b0, r_feat};
    assign o_m_tuser = {r_ovr_o, r_fid};
    assign o_m_tlast = r_lst;

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("input taken while result pending");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_LEN) else $error("sample count beyond limit");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV) else $error("divider done outside divide");
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MAC |-> 32'(r_k) < 32'(w_taps)) else $error("tap index past kernel");

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import cnv_pkg::*;

    localparam int N_FILT     = 8;
    localparam int N_TAPS     = 8;
    localparam int SEQ_MAX    = 256;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYC  = 120;

    typedef struct {
        logic [2:0]  filter_id;
        logic [30:0] feature;
        logic        overrun;
        logic        last_of_run;
    } feature_t;

    // Mirrors the encoder: stores, window, pooled sums, and expected features.
    class feature_scoreboard;
        int       tap_mem [N_FILT][N_TAPS];
        int       bias_mem[N_FILT];
        int       hist[N_TAPS];          // 0 = newest sample
        longint   pool[N_FILT];
        int       seq_cnt;
        bit       ovr;
        int       nf_reg;
        int       kt_reg;
        feature_t pending[$];
        int       errors;

        function new();
            nf_reg = 8;
            kt_reg = 3;
            clear_seq();
            errors = 0;
        endfunction

        function void clear_seq();
            foreach (hist[k]) hist[k] = 0;
            foreach (pool[f]) pool[f] = 0;
            seq_cnt = 0;
            ovr = 0;
        endfunction

        function void write_reg(logic idx, logic [3:0] val);
            if (idx == CFG_NUM_FILTERS) nf_reg = val;
            else kt_reg = val;
        endfunction

        function void fold_window(int f, int win[N_TAPS], int kt);
            longint conv;
            longint s;
            conv = longint'(bias_mem[f]) * 4096;
            for (int k = 0; k < kt; k++)
                conv += longint'(win[k]) * longint'(tap_mem[f][k]);
            if (conv <= 0) return;
            s = pool[f] + (conv >>> 12);
            pool[f] = (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
        endfunction

        function void note_beat(logic [1:0] act, logic [2:0] fs, logic [2:0] ts,
                                logic signed [15:0] cf, logic signed [15:0] sm, logic lst);
            int       nf;
            int       kt;
            int       steps;
            int       j;
            int       win[N_TAPS];
            longint   q;
            feature_t r;
            if (act == ACT_TAP) begin
                tap_mem[fs][ts] = cf;
                return;
            end
            if (act == ACT_BIAS) begin
                bias_mem[fs] = cf;
                return;
            end
            if (act != ACT_SAMPLE) return;
            nf = (nf_reg == 0) ? 1 : (nf_reg > N_FILT) ? N_FILT : nf_reg;
            kt = (kt_reg == 0) ? 1 : (kt_reg > N_TAPS) ? N_TAPS : kt_reg;
            foreach (win[k]) win[k] = 0;
            if (seq_cnt >= SEQ_MAX) begin
                ovr = 1;
            end else begin
                for (int k = N_TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
                hist[0] = sm;
                seq_cnt++;
                if (seq_cnt >= kt) begin
                    for (int k = 0; k < kt; k++) win[k] = hist[kt-1-k];
                    for (int f = 0; f < nf; f++) fold_window(f, win, kt);
                end
            end
            if (!lst) return;
            if (seq_cnt >= kt) begin
                steps = seq_cnt - kt + 1;
            end else begin
                steps = 1;
                // short run: pad with its final sample
                if (seq_cnt > 0) begin
                    for (int k = 0; k < kt; k++) begin
                        j = (k < seq_cnt) ? k : seq_cnt - 1;
                        win[k] = hist[seq_cnt-1-j];
                    end
                    for (int f = 0; f < nf; f++) fold_window(f, win, kt);
                end
            end
            for (int f = 0; f < nf; f++) begin
                q = pool[f] / steps;
                if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
                r.filter_id   = 3'(f);
                r.feature     = q[30:0];
                r.overrun     = ovr;
                r.last_of_run = (f == nf - 1);
                pending.insert(pending.size(), r);
            end
            clear_seq();
        endfunction

        function void check_feature(logic [2:0] fid, logic [30:0] feat, logic ov, logic lr);
            feature_t e;
            if (pending.size() == 0) begin
                $error("unexpected feature beat: filter_id %0d feature %0d", fid, feat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (fid !== e.filter_id) begin
                $error("filter_id: expected %0d actual %0d", e.filter_id, fid);
                errors++;
            end
            if (feat !== e.feature) begin
                $error("feature: expected %0d actual %0d", e.feature, feat);
                errors++;
            end
            if (ov !== e.overrun) begin
                $error("overrun: expected %0d actual %0d", e.overrun, ov);
                errors++;
            end
            if (lr !== e.last_of_run) begin
                $error("last_of_run: expected %0d actual %0d", e.last_of_run, lr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic [39:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        s_last = 0;
    logic        m_ready = 0;
    logic        cfg_valid = 0;
    logic        cfg_index = 0;
    logic [3:0]  cfg_data = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [31:0] o_m_tdata;
    wire  [3:0]  o_m_tuser;
    wire         o_m_tlast;
    wire         o_cfg_ready;

    feature_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    conv1d_relu_avgpool_encoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .i_s_tlast   (s_last),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Receive side: check each feature beat, then roll the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_ready)
            sb.check_feature(o_m_tuser[2:0], o_m_tdata[30:0], o_m_tuser[3], o_m_tlast);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) || (cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one input beat; hold it until accepted.
    task automatic send_beat(logic [1:0] act, logic [2:0] fs, logic [2:0] ts,
                             logic [15:0] cf, logic [15:0] sm, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge i_clk);
        end
        s_valid <= 1;
        s_user  <= act;
        s_data  <= {2'b00, sm, cf, ts, fs};
        s_last  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_beat(act, fs, ts, cf, sm, lst);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_all();
        for (int f = 0; f < N_FILT; f++) begin
            for (int t = 0; t < N_TAPS; t++)
                send_beat(ACT_TAP, 3'(f), 3'(t), rand_val(), 16'($urandom), 0);
            send_beat(ACT_BIAS, 3'(f), 3'($urandom), rand_val(), 16'($urandom), 0);
        end
    endtask

    task automatic send_run(int len);
        for (int n = 0; n < len; n++)
            send_beat(ACT_SAMPLE, 3'($urandom), 3'($urandom), 16'($urandom), rand_val(),
                      n == len - 1);
    endtask

    initial begin
        int sent;
        int len;
        int phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Every store entry is written before any window reads it.
        load_all();

        // Directed: extreme taps and samples, a single-sample run, ignored action.
        for (int t = 0; t < N_TAPS; t++) send_beat(ACT_TAP, 0, 3'(t), 16'h7FFF, 16'h0, 0);
        send_beat(ACT_BIAS, 0, 0, 16'h7FFF, 16'h0, 0);
        send_beat(ACT_BIAS, 7, 7, 16'h8000, 16'hFFFF, 0);
        send_beat(2'd3, 3'h7, 3'h7, 16'hFFFF, 16'hFFFF, 1);
        send_beat(ACT_SAMPLE, 0, 0, 0, 16'h7FFF, 1);
        send_beat(ACT_SAMPLE, 0, 0, 0, 16'h7FFF, 0);
        send_beat(ACT_SAMPLE, 0, 0, 0, 16'h8000, 1);
        send_beat(ACT_SAMPLE, 0, 0, 0, 16'h7FFF, 0);
        send_beat(ACT_SAMPLE, 0, 0, 0, 16'h7FFF, 0);
        send_beat(ACT_SAMPLE, 0, 0, 0, 16'h7FFF, 1);

        // Overrun: push past the length cap, last beat is dropped but still ends the run.
        for (int n = 0; n < SEQ_MAX + 3; n++)
            send_beat(ACT_SAMPLE, 0, 0, 0, 16'h7FFF, n == SEQ_MAX + 2);

        sent = 0;
        phase = 0;
        while (phase < 4 || sent < 48) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            case (phase)
                0: begin write_reg(CFG_NUM_FILTERS, 8);  write_reg(CFG_KERNEL_TAPS, 8);  end
                1: begin write_reg(CFG_NUM_FILTERS, 1);  write_reg(CFG_KERNEL_TAPS, 1);  end
                2: begin write_reg(CFG_NUM_FILTERS, 0);  write_reg(CFG_KERNEL_TAPS, 15); end
                3: begin write_reg(CFG_NUM_FILTERS, 15); write_reg(CFG_KERNEL_TAPS, 0);  end
                default: begin
                    write_reg(CFG_NUM_FILTERS, 4'($urandom));
                    write_reg(CFG_KERNEL_TAPS, 4'($urandom));
                end
            endcase
            for (int r = 0; r < 3; r++) begin
                case ($urandom_range(9))
                    0: begin
                        send_beat(ACT_TAP, 3'($urandom), 3'($urandom), rand_val(),
                                  16'($urandom), 1'($urandom));
                        send_beat(ACT_BIAS, 3'($urandom), 3'($urandom), rand_val(),
                                  16'($urandom), 1'($urandom));
                    end
                    1: send_beat(2'd3, 3'($urandom), 3'($urandom), 16'($urandom),
                                 16'($urandom), 1'($urandom));
                    default: begin
                        len = $urandom_range(1, 12);
                        send_run(len);
                        sent += len;
                    end
                endcase
            end
            phase++;
        end

        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/cnv_pkg.sv
hw/rtl/cnv_cell.sv
hw/rtl/cnv_div.sv
hw/rtl/conv1d_relu_avgpool_encoder_top.sv
dv/tb.sv
